/* rtl/core/bbd_pkg.sv */
// Shared types, widths and codes for the bilinear Bayer demosaic core.
// Depends on nothing; every other file of the core imports it.
package bbd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_ROWS   = 16384;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int WIDTH_W    = COL_W + 1;
    localparam int HEIGHT_W   = ROW_W + 1;
    localparam int CNT_W      = WIDTH_W + HEIGHT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(4096);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4096);

    // Bayer pattern codes
    localparam logic [1:0] PAT_RGGB = 2'd0;
    localparam logic [1:0] PAT_BGGR = 2'd1;
    localparam logic [1:0] PAT_GRBG = 2'd2;
    localparam logic [1:0] PAT_GBRG = 2'd3;

    // Input item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    // Site colour of an output pixel
    localparam logic [1:0] SITE_RED       = 2'd0;
    localparam logic [1:0] SITE_BLUE      = 2'd1;
    localparam logic [1:0] SITE_GREEN_RED = 2'd2;  // green on a red row
    localparam logic [1:0] SITE_GREEN_BLU = 2'd3;  // green on a blue row

    // Queues
    localparam int OPQ_DEPTH   = 4;
    localparam int OPQ_PTR_W   = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W   = OPQ_PTR_W + 1;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = OUTQ_PTR_W + 1;

    typedef struct packed {
        logic [COL_W-1:0]    col;
        logic [SAMPLE_W-1:0] sample;
        logic                emit;
        logic                lft;
        logic                rgt;
        logic                top;
        logic                bot;
        logic                last;
        logic [1:0]          site;
    } op_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                frame_last;
    } pixel_t;

endpackage

/* rtl/core/bilinear_bayer_demosaic_core.sv */
// Top level of the bilinear Bayer demosaic core.
// Instantiates bbd_front, bbd_back and bbd_outq; uses bbd_pkg.
//
// Raw Bayer samples enter in raster order, one per beat, and RGB pixels leave
// in the same order, image_width+1 input beats behind. The core sustains one
// input beat per clock while the consumer keeps popping: the line store is a
// single 4096 x 32 memory holding the upper and middle lines side by side,
// read once and written once each cycle, and all interpolation sits in one
// stage after the 3x3 window. An item passes a front stage (classify and
// count), a four-entry op queue, a memory read stage, a window stage and the
// eight-entry result queue on its way to the result ports.
// full rises only when the consumer stops popping and both queues fill up.
// Each pixel's own colour passes through; the other two are truncated means
// of the left/right pair, the up/down pair, the four cardinal or the four
// diagonal neighbours, with neighbours clamped at the image border. After
// width*height samples, send drain beats (func = 1) to flush the last
// width+1 pixels; drain beats sent earlier are dropped. frame_last marks the
// final pixel, after which the next beat starts a new frame. Write the size
// and pattern registers only between frames. The line store has no reset
// and no clearing pass; its unwritten entries never reach a result.
module bilinear_bayer_demosaic_core
    import bbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input queue side
    input  logic                  push,
    output logic                  full,
    input  logic                  func,
    input  logic [SAMPLE_W-1:0]   sample,
    // result queue side
    output logic                  empty,
    input  logic                  pop,
    output logic [SAMPLE_W-1:0]   red,
    output logic [SAMPLE_W-1:0]   green,
    output logic [SAMPLE_W-1:0]   blue,
    output logic                  frame_last,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                  op_valid;
    op_t                   op;
    logic                  op_pop;
    logic                  res_push;
    pixel_t                res;
    pixel_t                pix;
    logic [OUTQ_CNT_W-1:0] outq_count;

    // Classify beats, track the raster position, queue ops
    bbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .sample    (sample),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .op_valid  (op_valid),
        .op        (op),
        .op_pop    (op_pop)
    );

    // Line stores, window and interpolation; issue against result queue credit
    bbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op         (op),
        .op_pop     (op_pop),
        .outq_count (outq_count),
        .res_push   (res_push),
        .res        (res)
    );

    // Hold finished pixels until the consumer pops them
    bbd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (res_push),
        .din   (res),
        .rd_en (pop),
        .empty (empty),
        .dout  (pix),
        .count (outq_count)
    );

    assign red        = pix.red;
    assign green      = pix.green;
    assign blue       = pix.blue;
    assign frame_last = pix.frame_last;

endmodule

/* rtl/core/bbd_front.sv */
// Front end of the demosaic core: configuration registers, frame counters,
// item classification and the short op queue toward the back end. Uses bbd_pkg.
module bbd_front
    import bbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  func,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  op_valid,
    output op_t                   op,
    input  logic                  op_pop
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [1:0]          pattern_reg;
    logic [CNT_W-1:0]    total_reg;

    logic [WIDTH_W-1:0]  wr_width;
    logic [HEIGHT_W-1:0] wr_height;
    logic [WIDTH_W-1:0]  width_sel;
    logic [HEIGHT_W-1:0] height_sel;
    logic [CNT_W-1:0]    total_next;

    logic [COL_W-1:0]    in_col_reg,  in_col_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic [CNT_W-1:0]    taken_reg,   taken_next;

    logic                accept;
    logic                early;
    logic                op_push;
    logic                col_wrap;
    logic                rdx;
    logic                rdy;
    op_t                 op_in;

    op_t                 opq_mem [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg;
    logic [OPQ_CNT_W-1:0] count_reg, count_next;

    // Clamp written sizes into their legal ranges
    always_comb
    begin
        wr_width = cfg_wdata[WIDTH_W-1:0];
        if (wr_width == '0)
            wr_width = WIDTH_W'(1);
        else if (wr_width > WIDTH_W'(MAX_WIDTH))
            wr_width = WIDTH_W'(MAX_WIDTH);
        wr_height = cfg_wdata[HEIGHT_W-1:0];
        if (wr_height == '0)
            wr_height = HEIGHT_W'(1);
        else if (wr_height > HEIGHT_W'(MAX_ROWS))
            wr_height = HEIGHT_W'(MAX_ROWS);
    end

    assign width_sel  = (cfg_wr_en && cfg_idx == CFG_WIDTH)  ? wr_width  : width_reg;
    assign height_sel = (cfg_wr_en && cfg_idx == CFG_HEIGHT) ? wr_height : height_reg;
    assign total_next = CNT_W'(width_sel) * CNT_W'(height_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            pattern_reg <= PAT_RGGB;
            total_reg   <= CNT_W'(WIDTH_RESET) * CNT_W'(HEIGHT_RESET);
        end
        else if (cfg_wr_en)
        begin
            width_reg  <= width_sel;
            height_reg <= height_sel;
            total_reg  <= total_next;
            if (cfg_idx == CFG_PATTERN)
                pattern_reg <= cfg_wdata[1:0];
        end
    end

    // Red site position in the 2x2 cell
    always_comb
    begin
        unique case (pattern_reg)
            PAT_BGGR: begin rdx = 1'b1; rdy = 1'b1; end
            PAT_GRBG: begin rdx = 1'b1; rdy = 1'b0; end
            PAT_GBRG: begin rdx = 1'b0; rdy = 1'b1; end
            default:  begin rdx = 1'b0; rdy = 1'b0; end
        endcase
    end

    assign accept   = push && !full;
    assign early    = (func == FUNC_DRAIN) && (taken_reg < total_reg);
    assign op_push  = accept && !early;
    assign col_wrap = (WIDTH_W'(in_col_reg) + WIDTH_W'(1)) >= width_reg;

    always_comb
    begin
        op_in.col    = in_col_reg;
        op_in.sample = (func == FUNC_DRAIN) ? '0 : sample;
        op_in.emit   = taken_reg > CNT_W'(width_reg);
        op_in.lft    = out_col_reg == '0;
        op_in.rgt    = (WIDTH_W'(out_col_reg) + WIDTH_W'(1)) >= width_reg;
        op_in.top    = out_row_reg == '0;
        op_in.bot    = (HEIGHT_W'(out_row_reg) + HEIGHT_W'(1)) >= height_reg;
        op_in.last   = op_in.emit && op_in.bot && op_in.rgt;
        if (out_col_reg[0] == rdx && out_row_reg[0] == rdy)
            op_in.site = SITE_RED;
        else if (out_col_reg[0] != rdx && out_row_reg[0] != rdy)
            op_in.site = SITE_BLUE;
        else if (out_row_reg[0] == rdy)
            op_in.site = SITE_GREEN_RED;
        else
            op_in.site = SITE_GREEN_BLU;
    end

    // Advance the raster counters; the final pixel of the frame clears them all
    always_comb
    begin
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        taken_next   = taken_reg;
        if (op_push)
        begin
            if (op_in.last)
            begin
                in_col_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                taken_next   = '0;
            end
            else
            begin
                taken_next  = taken_reg + CNT_W'(1);
                in_col_next = col_wrap ? '0 : in_col_reg + COL_W'(1);
                if (op_in.emit)
                begin
                    if (op_in.rgt)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end
                    else
                        out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            taken_reg   <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            taken_reg   <= taken_next;
        end
    end

    // Op queue
    assign full     = count_reg == OPQ_CNT_W'(OPQ_DEPTH);
    assign op_valid = count_reg != '0;
    assign op       = opq_mem[rd_ptr_reg];

    always_comb
    begin
        unique case ({op_push, op_pop})
            2'b10:   count_next = count_reg + OPQ_CNT_W'(1);
            2'b01:   count_next = count_reg - OPQ_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (op_push)
                wr_ptr_reg <= wr_ptr_reg + OPQ_PTR_W'(1);
            if (op_pop)
                rd_ptr_reg <= rd_ptr_reg + OPQ_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_push)
            opq_mem[wr_ptr_reg] <= op_in;
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> count_reg != '0)
        else $error("op queue popped while empty");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        op_push && op_in.last |=> taken_reg == '0 && in_col_reg == '0
                                  && out_col_reg == '0 && out_row_reg == '0)
        else $error("frame counters not cleared after final pixel");

    a_early_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && early |=> $stable(taken_reg) && $stable(out_col_reg)
                            && $stable(in_col_reg))
        else $error("early drain changed frame state");

endmodule

/* rtl/core/bbd_back.sv */
// Back end of the demosaic core: line store memory, 3x3 window and the
// bilinear interpolation of one pixel per emitting op. Uses bbd_pkg.
module bbd_back
    import bbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    input  op_t                   op,
    output logic                  op_pop,
    input  logic [OUTQ_CNT_W-1:0] outq_count,
    output logic                  res_push,
    output pixel_t                res
);

    // Upper line in the high half, middle line in the low half
    logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];

    logic                  a_valid_reg;
    op_t                   a_op_reg;
    logic [2*SAMPLE_W-1:0] rd_reg;
    logic                  fwd_reg;
    logic [2*SAMPLE_W-1:0] fwd_data_reg;
    logic [2*SAMPLE_W-1:0] pair_eff;
    logic [2*SAMPLE_W-1:0] wr_data;

    logic                  b_valid_reg;
    op_t                   b_op_reg;
    logic [SAMPLE_W-1:0]   win_reg [3][3];

    logic [OUTQ_CNT_W:0]   used;

    logic [SAMPLE_W-1:0]   up_c, dn_c, lf_c, rt_c;
    logic [SAMPLE_W-1:0]   t0, t2, b0, b2;
    logic [SAMPLE_W-1:0]   tl, tr, bl, br;
    logic [SAMPLE_W:0]     sum_h, sum_v;
    logic [SAMPLE_W+1:0]   sum_card, sum_diag;
    logic [SAMPLE_W-1:0]   pair_h, pair_v, card, diag, cen;

    // Issue only when the result queue has room for everything in flight
    assign used   = (OUTQ_CNT_W+1)'(outq_count)
                  + (OUTQ_CNT_W+1)'(a_valid_reg && a_op_reg.emit)
                  + (OUTQ_CNT_W+1)'(b_valid_reg);
    assign op_pop = op_valid && (used < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

    assign pair_eff = fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_data  = {pair_eff[SAMPLE_W-1:0], a_op_reg.sample};

    // Read on issue, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (op_pop)
            rd_reg <= line_mem[op.col];
        if (a_valid_reg)
            line_mem[a_op_reg.col] <= wr_data;
        if (op_pop)
        begin
            a_op_reg     <= op;
            fwd_data_reg <= wr_data;
        end
        if (a_valid_reg)
            b_op_reg <= a_op_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            a_valid_reg <= op_pop;
            if (op_pop)
                fwd_reg <= a_valid_reg && (a_op_reg.col == op.col);
            b_valid_reg <= a_valid_reg && a_op_reg.emit;
            if (a_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= pair_eff[2*SAMPLE_W-1:SAMPLE_W];
                win_reg[1][2] <= pair_eff[SAMPLE_W-1:0];
                win_reg[2][2] <= a_op_reg.sample;
            end
        end
    end

    // Edge clamped neighbours: an outside neighbour takes the centre row or column
    always_comb
    begin
        cen  = win_reg[1][1];
        up_c = b_op_reg.top ? win_reg[1][1] : win_reg[0][1];
        dn_c = b_op_reg.bot ? win_reg[1][1] : win_reg[2][1];
        lf_c = b_op_reg.lft ? win_reg[1][1] : win_reg[1][0];
        rt_c = b_op_reg.rgt ? win_reg[1][1] : win_reg[1][2];
        t0   = b_op_reg.top ? win_reg[1][0] : win_reg[0][0];
        t2   = b_op_reg.top ? win_reg[1][2] : win_reg[0][2];
        b0   = b_op_reg.bot ? win_reg[1][0] : win_reg[2][0];
        b2   = b_op_reg.bot ? win_reg[1][2] : win_reg[2][2];
        tl   = b_op_reg.lft ? up_c : t0;
        tr   = b_op_reg.rgt ? up_c : t2;
        bl   = b_op_reg.lft ? dn_c : b0;
        br   = b_op_reg.rgt ? dn_c : b2;

        sum_h    = (SAMPLE_W+1)'(lf_c) + (SAMPLE_W+1)'(rt_c);
        sum_v    = (SAMPLE_W+1)'(up_c) + (SAMPLE_W+1)'(dn_c);
        sum_card = (SAMPLE_W+2)'(sum_h) + (SAMPLE_W+2)'(sum_v);
        sum_diag = (SAMPLE_W+2)'(tl) + (SAMPLE_W+2)'(tr)
                 + (SAMPLE_W+2)'(bl) + (SAMPLE_W+2)'(br);
        pair_h   = sum_h[SAMPLE_W:1];
        pair_v   = sum_v[SAMPLE_W:1];
        card     = sum_card[SAMPLE_W+1:2];
        diag     = sum_diag[SAMPLE_W+1:2];

        res.frame_last = b_op_reg.last;
        unique case (b_op_reg.site)
            SITE_RED:
            begin
                res.red = cen;  res.green = card; res.blue = diag;
            end
            SITE_BLUE:
            begin
                res.red = diag; res.green = card; res.blue = cen;
            end
            SITE_GREEN_RED:
            begin
                res.red = pair_h; res.green = cen; res.blue = pair_v;
            end
            default:
            begin
                res.red = pair_v; res.green = cen; res.blue = pair_h;
            end
        endcase
    end

    assign res_push = b_valid_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> outq_count < OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result pushed into a full result queue");

endmodule

/* rtl/core/bbd_outq.sv */
// Result queue of the demosaic core; holds finished pixels for the consumer.
// Uses bbd_pkg.
module bbd_outq
    import bbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  pixel_t                din,
    input  logic                  rd_en,
    output logic                  empty,
    output pixel_t                dout,
    output logic [OUTQ_CNT_W-1:0] count
);

    pixel_t                mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_rd;

    assign empty = count_reg == '0;
    assign count = count_reg;
    assign dout  = mem[rd_ptr_reg];
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        unique case ({wr_en, do_rd})
            2'b10:   count_next = count_reg + OUTQ_CNT_W'(1);
            2'b01:   count_next = count_reg - OUTQ_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= din;
    end

endmodule
